@@ design/prd_pkg.sv @@
// Package for the position repetition detector: sizes, constants and payload types.
`default_nettype none

package prd_pkg;

  localparam int HISTORY_DEPTH = 128;
  localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int HASH_W        = 64;
  localparam int CLK_W         = 10;
  localparam int CMP_W         = (CLK_W > CNT_W) ? CLK_W : CNT_W;

  localparam logic [CLK_W-1:0] CLOCK_MAX = CLK_W'(1023);
  localparam int FIRST_DIST = 4;
  localparam int DIST_STEP  = 2;

  typedef logic [ADDR_W-1:0] prd_addr_t;
  typedef logic [HASH_W-1:0] prd_hash_t;

  typedef struct packed {
    logic              start_new;
    logic [HASH_W-1:0] position_hash;
    logic              irreversible;
    logic [CLK_W-1:0]  clock_init;
  } prd_in_t;

  typedef struct packed {
    logic             twofold;
    logic             threefold;
    logic [CLK_W-1:0] halfmove_clock_out;
  } prd_out_t;

  // History memory access, one write and one read port.
  typedef struct packed {
    logic      we;
    prd_addr_t waddr;
    prd_hash_t wdata;
    logic      re;
    prd_addr_t raddr;
  } prd_mem_req_t;

endpackage

`default_nettype wire

@@ design/prd_hist_mem.sv @@
// Hash history ring storage: one write port, one read port with registered data.
`default_nettype none

module prd_hist_mem
  import prd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire prd_mem_req_t req_i,
  output prd_hash_t         rdata_o
);

  prd_hash_t mem_q [HISTORY_DEPTH];
  prd_hash_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/position_repetition_detector_unit.sv @@
// Position repetition detector: stores ply hashes and scans same-side history for repeats.
//
//   channel | signals                             | direction | payload
//   --------+-------------------------------------+-----------+----------------------------
//   input   | in_valid_i, in_stall_o, in_data_i   | in        | start, hash, irrev, clk init
//   output  | out_valid_o, out_stall_i, out_data_o| out       | twofold, threefold, clock
//
// One ply makes N history compares, N up to HISTORY_DEPTH/2 - 2 (62 at depth 128). The
// single memory read port sets the pace of the scan: one stored hash is fetched and
// compared per cycle.
// Reset clears the control state and the counters; history contents are left as they are.
// A stalled result waits in the output register; the next ply is taken meanwhile, and its
// result is held back until the register frees.
`default_nettype none

module position_repetition_detector_unit
  import prd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire prd_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output prd_out_t     out_data_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;

  logic [2:0]       state_q, state_d;
  prd_addr_t        wslot_q, wslot_d;
  prd_addr_t        cur_q, cur_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CLK_W-1:0] clock_q, clock_d;
  prd_hash_t        hash_q, hash_d;
  prd_addr_t        addr_q, addr_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [1:0]       matches_q, matches_d;
  logic             out_valid_q, out_valid_d;
  prd_out_t         out_q, out_d;

  prd_mem_req_t     mem_req;
  prd_hash_t        mem_rdata;

  logic             in_acc;
  logic [CMP_W-1:0] clock_ext, prev_ext;
  logic [CNT_W-1:0] limit;
  logic             hit;

  prd_hist_mem u_hist_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign in_acc = in_valid_i && (state_q == ST_IDLE);

  // Search window: clock vs. earlier stored entries (count - 1 never exceeds depth - 1).
  assign clock_ext = CMP_W'(clock_q);
  assign prev_ext  = CMP_W'(count_q - CNT_W'(1));
  assign limit     = (clock_ext < prev_ext) ? CNT_W'(clock_ext) : CNT_W'(prev_ext);

  assign hit = cmp_vld_q && (mem_rdata == hash_q);

  always_comb begin
    state_d     = state_q;
    wslot_d     = wslot_q;
    cur_d       = cur_q;
    count_d     = count_q;
    clock_d     = clock_q;
    hash_d      = hash_q;
    addr_d      = addr_q;
    rem_d       = rem_q;
    cmp_vld_d   = 1'b0;
    matches_d   = matches_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    mem_req       = '0;
    mem_req.waddr = cur_d;
    mem_req.wdata = in_data_i.position_hash;
    mem_req.raddr = addr_q;

    if (hit && (matches_q != 2'd2)) begin
      matches_d = matches_q + 2'd1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          hash_d    = in_data_i.position_hash;
          matches_d = 2'd0;
          if (in_data_i.start_new) begin
            cur_d   = '0;
            count_d = CNT_W'(1);
            clock_d = in_data_i.clock_init;
          end else begin
            cur_d = wslot_q;
            if (count_q != CNT_W'(HISTORY_DEPTH)) begin
              count_d = count_q + CNT_W'(1);
            end
            if (in_data_i.irreversible) begin
              clock_d = '0;
            end else if (clock_q != CLOCK_MAX) begin
              clock_d = clock_q + CLK_W'(1);
            end
          end
          mem_req.we    = 1'b1;
          mem_req.waddr = cur_d;
          wslot_d = (cur_d == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : cur_d + ADDR_W'(1);
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (limit >= CNT_W'(FIRST_DIST)) begin
          rem_d = ((limit - CNT_W'(FIRST_DIST)) >> 1) + CNT_W'(1);
        end else begin
          rem_d = '0;
        end
        addr_d = (cur_q >= ADDR_W'(FIRST_DIST)) ? cur_q - ADDR_W'(FIRST_DIST)
                                                : cur_q + ADDR_W'(HISTORY_DEPTH - FIRST_DIST);
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (rem_q != '0) begin
          mem_req.re = 1'b1;
          cmp_vld_d  = 1'b1;
          rem_d      = rem_q - CNT_W'(1);
          addr_d = (addr_q >= ADDR_W'(DIST_STEP)) ? addr_q - ADDR_W'(DIST_STEP)
                                                  : addr_q + ADDR_W'(HISTORY_DEPTH - DIST_STEP);
        end else if (!cmp_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d              = 1'b1;
          out_d.twofold            = (matches_q != 2'd0);
          out_d.threefold          = (matches_q == 2'd2);
          out_d.halfmove_clock_out = clock_q;
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wslot_q     <= '0;
      count_q     <= '0;
      clock_q     <= '0;
      rem_q       <= '0;
      cmp_vld_q   <= 1'b0;
      matches_q   <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wslot_q     <= wslot_d;
      count_q     <= count_d;
      clock_q     <= clock_d;
      rem_q       <= rem_d;
      cmp_vld_q   <= cmp_vld_d;
      matches_q   <= matches_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    hash_q <= hash_d;
    addr_q <= addr_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A transaction on the input always starts a multi-cycle scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.threefold || out_data_o.twofold))
    else $error("threefold without twofold");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(HISTORY_DEPTH))
    else $error("stored count beyond ring depth");

  // No scan activity may survive into idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (rem_q == '0) && !cmp_vld_q)
    else $error("scan still active in idle");

endmodule

`default_nettype wire
